>>> design/arsc_pkg.sv
`default_nettype none

package arsc_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		ACT_MALLOC = 3'd0,
		ACT_FREE   = 3'd1,
		ACT_LOAD   = 3'd2,
		ACT_STORE  = 3'd3,
		ACT_STACK  = 3'd4,
		ACT_EXIT   = 3'd5
	} act_t;

	typedef enum logic [3:0] {
		STS_OK           = 4'd0,
		STS_DOUBLE_FREE  = 4'd1,
		STS_FREE_UNALLOC = 4'd2,
		STS_LOAD_UAF     = 4'd3,
		STS_STORE_UAF    = 4'd4,
		STS_LOAD_UNALLOC = 4'd5,
		STS_STORE_UNALLOC = 4'd6,
		STS_LEAK         = 4'd7,
		STS_FULL         = 4'd8,
		STS_HALTED       = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREED = 2'd1,
		KIND_STACK = 2'd2
	} kind_t;

	typedef struct packed {
		logic [63:0] base;
		logic [31:0] len;
		kind_t       kind;
	} entry_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_SCAN,
		FSM_UPDATE
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_run;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic halted;
		logic needs_scan;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> design/arsc_ctrl.sv
`default_nettype none

module arsc_ctrl import arsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	fsm_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) state_nx = FSM_DECODE;
			end
			FSM_DECODE: begin
				state_nx = sts.needs_scan ? FSM_SCAN : FSM_UPDATE;
			end
			FSM_SCAN: begin
				if (sts.scan_done) state_nx = FSM_UPDATE;
			end
			FSM_UPDATE: begin
				if (sts.out_free) state_nx = FSM_IDLE;
			end
			default: state_nx = FSM_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			FSM_DECODE: begin
				cmd.scan_start = sts.needs_scan;
			end
			FSM_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			FSM_UPDATE: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/arsc_dp.sv
`default_nettype none

module arsc_dp import arsc_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [2:0]  action,
	input  wire logic [63:0] address,
	input  wire logic [31:0] byte_count,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [3:0]       status,
	output logic [63:0]      report_address
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;

	entry_t mem_q [TABLE_DEPTH];

	act_t        act_q;
	logic [63:0] addr_q;
	logic [31:0] bytes_q;
	logic [CW-1:0] count_q;
	logic        halted_q;

	logic [CW-1:0] rd_q;
	logic        vld_s1;
	logic [IW-1:0] idx_s1;
	entry_t      rd_data_s1;
	logic        done_q;
	logic        found_q;
	logic [IW-1:0] found_idx_q;
	entry_t      found_ent_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [63:0] report_q;

	logic [64:0] diff;
	logic        hit;
	logic        match;
	logic        last;
	logic        full;
	logic        rd_more;

	status_t     res_status;
	logic [63:0] res_report;
	logic        wr_en;
	logic [IW-1:0] wr_idx;
	entry_t      wr_ent;
	logic        append;
	logic        clear;
	logic        is_err;

	assign diff    = {1'b0, addr_q} - {1'b0, rd_data_s1.base};
	assign hit     = !diff[64] && (diff[63:0] < {32'd0, rd_data_s1.len});
	assign match   = (act_q == ACT_EXIT) ? (rd_data_s1.kind == KIND_ALLOC) : hit;
	assign last    = ({1'b0, idx_s1} + CW'(1)) == count_q;
	assign full    = count_q == CW'(TABLE_DEPTH);
	assign rd_more = rd_q < count_q;

	always_comb begin
		sts.halted    = halted_q;
		sts.scan_done = done_q;
		sts.out_free  = !out_valid_q || !out_stall;
		sts.needs_scan = 1'b0;
		if (!halted_q && (count_q != '0)) begin
			case (act_q)
				ACT_MALLOC, ACT_FREE, ACT_LOAD, ACT_STORE, ACT_EXIT: sts.needs_scan = 1'b1;
				default: sts.needs_scan = 1'b0;
			endcase
		end
	end

	always_comb begin
		res_status = STS_OK;
		res_report = addr_q;
		wr_en      = 1'b0;
		wr_idx     = found_idx_q;
		wr_ent     = found_ent_q;
		append     = 1'b0;
		clear      = 1'b0;
		if (halted_q) begin
			res_status = STS_HALTED;
			res_report = '0;
		end else begin
			case (act_q)
				ACT_MALLOC: begin
					if (found_q) begin
						wr_en       = 1'b1;
						wr_ent.kind = KIND_ALLOC;
					end else if (full) begin
						res_status = STS_FULL;
					end else begin
						append = 1'b1;
						wr_ent = '{base: addr_q, len: bytes_q, kind: KIND_ALLOC};
					end
				end
				ACT_FREE: begin
					if (!found_q) begin
						res_status = STS_FREE_UNALLOC;
					end else if (found_ent_q.kind == KIND_FREED) begin
						res_status = STS_DOUBLE_FREE;
					end else begin
						wr_en       = 1'b1;
						wr_ent.kind = KIND_FREED;
					end
				end
				ACT_LOAD, ACT_STORE: begin
					if (!found_q) begin
						res_status = (act_q == ACT_LOAD) ? STS_LOAD_UNALLOC : STS_STORE_UNALLOC;
					end else if (found_ent_q.kind == KIND_FREED) begin
						res_status = (act_q == ACT_LOAD) ? STS_LOAD_UAF : STS_STORE_UAF;
					end
				end
				ACT_STACK: begin
					if (full) begin
						res_status = STS_FULL;
					end else begin
						append = 1'b1;
						wr_ent = '{base: addr_q, len: 32'd1, kind: KIND_STACK};
					end
				end
				ACT_EXIT: begin
					if (found_q) begin
						res_status = STS_LEAK;
						res_report = found_ent_q.base;
					end else begin
						clear      = 1'b1;
						res_report = '0;
					end
				end
				default: begin
					res_report = '0;
				end
			endcase
		end
		if (append) begin
			wr_en  = 1'b1;
			wr_idx = count_q[IW-1:0];
		end
	end

	assign is_err = (res_status != STS_OK) && (res_status != STS_FULL) &&
		(res_status != STS_HALTED);

	// table storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem_q[wr_idx] <= wr_ent;
		end
		rd_data_s1 <= mem_q[rd_q[IW-1:0]];
		idx_s1     <= rd_q[IW-1:0];
		if (cmd.capture) begin
			act_q   <= act_t'(action);
			addr_q  <= address;
			bytes_q <= byte_count;
		end
		if (cmd.scan_run && !done_q && vld_s1 && match) begin
			found_idx_q <= idx_s1;
			found_ent_q <= rd_data_s1;
		end
		if (cmd.commit) begin
			status_q <= res_status;
			report_q <= res_report;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			halted_q    <= 1'b0;
			rd_q        <= '0;
			vld_s1      <= 1'b0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				found_q <= 1'b0;
				done_q  <= 1'b0;
			end
			if (cmd.scan_start) begin
				rd_q   <= '0;
				vld_s1 <= 1'b0;
				done_q <= 1'b0;
			end else if (cmd.scan_run && !done_q) begin
				vld_s1 <= rd_more;
				if (rd_more) rd_q <= rd_q + CW'(1);
				if (vld_s1) begin
					if (match) begin
						found_q <= 1'b1;
						done_q  <= 1'b1;
					end else if (last) begin
						done_q <= 1'b1;
					end
				end
			end
			if (cmd.commit) begin
				if (append) count_q <= count_q + CW'(1);
				else if (clear) count_q <= '0;
				if (is_err) halted_q <= 1'b1;
			end
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign report_address = report_q;

endmodule

`default_nettype wire

>>> design/allocation_region_safety_checker_core.sv
`default_nettype none

// channel  signals                                    dir  beat
// in       in_valid, in_stall, action, address,       in   one event
//          byte_count
// out      out_valid, out_stall, status,              out  one result
//          report_address
//
// One event at a time. An event occupies the block while it scans the regions up to
// the first match (at most the fill count, so up to TABLE_DEPTH) through the single
// read port. Stack, unknown, halted and empty-table events skip the scan.
// Reset empties the table and clears halt; no clearing pass.
// A stalled result waits in the output register; the next event is taken.

module allocation_region_safety_checker_core import arsc_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [63:0] address,
	input  wire logic [31:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       status,
	output logic [63:0]      report_address
);

	cmd_t cmd;
	sts_t sts;

	arsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	arsc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (action),
		.address        (address),
		.byte_count     (byte_count),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.report_address (report_address)
	);

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.halted |=> sts.halted)
		else $error("halt flag dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("event accepted while busy");

	a_halted_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_HALTED) |-> report_address == '0)
		else $error("halted result with nonzero address");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

endmodule

`default_nettype wire
